// ----- hdl/gbk_text_layout_defines.svh -----
// Assertion macros for the text layout block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef GBK_TEXT_LAYOUT_DEFINES_SVH
`define GBK_TEXT_LAYOUT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GBK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gbk_pkg.sv -----
// Shared types, constants and helper functions for the text layout block.
// No dependencies; imported by every module of the block.
package gbk_pkg;

  localparam int COORD_W  = 16;
  localparam int SIZE_W   = 5;
  localparam int ADDR_W   = 24;
  localparam int NBYTES_W = 7;
  localparam int ROW_W    = 7;
  localparam int COL_W    = 8;
  localparam int IDX_W    = 15;
  localparam int OFF_W    = 21;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam int QUEUE_DEPTH = 4;

  // GBK code layout
  localparam int        GBK_ROW_SPAN  = 190;
  localparam logic [7:0] LEAD_MIN     = 8'h81;
  localparam logic [7:0] TRAIL_MIN    = 8'h40;
  localparam logic [7:0] TRAIL_GAP    = 8'h7F;
  localparam logic [7:0] TRAIL_UP_BASE = 8'h41;
  localparam logic [7:0] CODE_INVALID = 8'hFF;
  localparam logic [7:0] ASCII_MAX    = 8'h80;
  localparam logic [7:0] CHAR_CR      = 8'd13;
  localparam logic [7:0] CHAR_NUL     = 8'd0;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Register reset values
  localparam logic [COORD_W-1:0] BOX_WIDTH_RST  = 16'd320;
  localparam logic [COORD_W-1:0] BOX_HEIGHT_RST = 16'd240;
  localparam logic [SIZE_W-1:0]  GLYPH_SIZE_RST = 5'd16;

  typedef enum logic [1:0] {
    DK_ASCII = 2'd0,
    DK_GLYPH = 2'd1,
    DK_BLANK = 2'd2
  } draw_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_BOX_WIDTH  = 3'd2,
    CFG_BOX_HEIGHT = 3'd3,
    CFG_GLYPH_SIZE = 3'd4,
    CFG_OVERLAY    = 3'd5,
    CFG_FONT_BASE  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_INDEX,
    BK_SCALE,
    BK_EMIT
  } bk_state_e;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] box_width;
    logic [COORD_W-1:0] box_height;
    logic [SIZE_W-1:0]  glyph_size;
    logic               overlay_mode;
    logic [ADDR_W-1:0]  font_base;
  } cfg_t;

  // One classified draw command between front and back.
  typedef struct packed {
    draw_kind_e          kind;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [7:0]          char_code;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic [NBYTES_W-1:0] nbytes;
    logic                overlay;
  } entry_t;

  typedef struct packed {
    draw_kind_e          draw_kind;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [7:0]          char_code;
    logic [ADDR_W-1:0]   glyph_addr;
    logic [NBYTES_W-1:0] glyph_bytes;
    logic                overlay;
  } result_t;

  typedef struct packed {
    logic halted;
    logic lead_pending;
    logic skip_after_cr;
  } fr_status_t;

  function automatic logic glyph_size_ok(logic [SIZE_W-1:0] gs);
    return (gs == 5'd12) || (gs == 5'd16) || (gs == 5'd24);
  endfunction

  // Bitmap bytes per glyph: one byte column per 8 rows, times the height.
  function automatic logic [NBYTES_W-1:0] glyph_nbytes(logic [SIZE_W-1:0] gs);
    logic [NBYTES_W-1:0] n;
    unique case (gs)
      5'd12:   n = 7'd24;
      5'd16:   n = 7'd32;
      5'd24:   n = 7'd72;
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

// ----- hdl/gbk_front.sv -----
// Front end: accepts string bytes, tracks cursor and GBK lead byte, and
// queues classified draw commands. Depends on gbk_pkg.
module gbk_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbk_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_op_i,
  input  logic [7:0]          in_byte_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output gbk_pkg::entry_t     q_entry_o,
  output gbk_pkg::fr_status_t status_o
);
  import gbk_pkg::*;

  logic [COORD_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [7:0]         lead_q, lead_d;
  logic               lead_pend_q, lead_pend_d;
  logic               skip_q, skip_d;
  logic               halted_q, halted_d;

  logic                  accept;
  logic [SIZE_W-1:0]     half;
  logic [SIZE_W-1:0]     adv;
  logic signed [18:0]    lim_x, lim_y;
  logic                  wrap;
  logic [COORD_W-1:0]    cx_w, cy_w;
  logic                  past;
  logic                  bad_code;
  logic [7:0]            trail;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign status_o   = '{halted: halted_q, lead_pending: lead_pend_q, skip_after_cr: skip_q};

  // Wrap and bottom checks; a pending lead byte means a full-width glyph.
  always_comb begin
    half  = cfg_i.glyph_size >> 1;
    adv   = lead_pend_q ? cfg_i.glyph_size : half;
    lim_x = 19'(cfg_i.origin_x) + 19'(cfg_i.box_width) - 19'(adv);
    wrap  = $signed({3'b000, cx_q}) > lim_x;
    cx_w  = wrap ? cfg_i.origin_x : cx_q;
    cy_w  = wrap ? cy_q + COORD_W'(cfg_i.glyph_size) : cy_q;
    lim_y = 19'(cfg_i.origin_y) + 19'(cfg_i.box_height) - 19'(cfg_i.glyph_size);
    past  = $signed({3'b000, cy_w}) > lim_y;
  end

  assign trail    = in_byte_i;
  assign bad_code = (lead_q < LEAD_MIN) || (lead_q == CODE_INVALID) || (trail < TRAIL_MIN) ||
                    (trail == TRAIL_GAP) || (trail == CODE_INVALID);

  always_comb begin
    cx_d        = cx_q;
    cy_d        = cy_q;
    lead_d      = lead_q;
    lead_pend_d = lead_pend_q;
    skip_d      = skip_q;
    halted_d    = halted_q;
    q_push_o    = 1'b0;

    q_entry_o.kind      = DK_ASCII;
    q_entry_o.pos_x     = cx_w;
    q_entry_o.pos_y     = cy_w;
    q_entry_o.char_code = in_byte_i;
    q_entry_o.row       = ROW_W'(lead_q - LEAD_MIN);
    q_entry_o.col       = (trail < TRAIL_GAP) ? (trail - TRAIL_MIN) : (trail - TRAIL_UP_BASE);
    q_entry_o.nbytes    = '0;
    q_entry_o.overlay   = cfg_i.overlay_mode;

    if (accept) begin
      priority if (in_op_i == OP_START) begin
        cx_d        = cfg_i.origin_x;
        cy_d        = cfg_i.origin_y;
        lead_d      = '0;
        lead_pend_d = 1'b0;
        skip_d      = 1'b0;
        halted_d    = 1'b0;
      end else if (halted_q) begin
        // drop everything until the next start
      end else if (in_byte_i == CHAR_NUL) begin
        halted_d    = 1'b1;
        lead_pend_d = 1'b0;
        skip_d      = 1'b0;
      end else if (skip_q) begin
        skip_d = 1'b0;
      end else if (lead_pend_q) begin
        lead_pend_d = 1'b0;
        cx_d        = cx_w;
        cy_d        = cy_w;
        if (past) begin
          halted_d = 1'b1;
        end else begin
          cx_d = cx_w + COORD_W'(cfg_i.glyph_size);
          if (glyph_size_ok(cfg_i.glyph_size)) begin
            q_push_o            = 1'b1;
            q_entry_o.kind      = bad_code ? DK_BLANK : DK_GLYPH;
            q_entry_o.char_code = '0;
            q_entry_o.nbytes    = glyph_nbytes(cfg_i.glyph_size);
          end
        end
      end else if (in_byte_i > ASCII_MAX) begin
        lead_d      = in_byte_i;
        lead_pend_d = 1'b1;
      end else begin
        cx_d = cx_w;
        cy_d = cy_w;
        if (past) begin
          halted_d = 1'b1;
        end else if (in_byte_i == CHAR_CR) begin
          cx_d   = cfg_i.origin_x;
          cy_d   = cy_w + COORD_W'(cfg_i.glyph_size);
          skip_d = 1'b1;
        end else begin
          q_push_o = 1'b1;
          cx_d     = cx_w + COORD_W'(half);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q        <= '0;
      cy_q        <= '0;
      lead_q      <= '0;
      lead_pend_q <= 1'b0;
      skip_q      <= 1'b0;
      halted_q    <= 1'b0;
    end else begin
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      lead_q      <= lead_d;
      lead_pend_q <= lead_pend_d;
      skip_q      <= skip_d;
      halted_q    <= halted_d;
    end
  end

endmodule

// ----- hdl/gbk_queue.sv -----
// Small command FIFO between the front and back ends.
// Depends on gbk_pkg for the entry type.
module gbk_queue #(
  parameter int Depth = gbk_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gbk_pkg::entry_t entry_i,
  input  logic            pop_i,
  output gbk_pkg::entry_t entry_o,
  output logic            full_o,
  output logic            empty_o
);
  import gbk_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- hdl/gbk_back.sv -----
// Back end: turns queued commands into results, computing the glyph flash
// address in two multiply steps, and holds the result register. Depends on gbk_pkg.
module gbk_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbk_pkg::cfg_t    cfg_i,
  input  logic             q_empty_i,
  input  gbk_pkg::entry_t  q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gbk_pkg::result_t out_o
);
  import gbk_pkg::*;

  bk_state_e          state_q, state_d;
  entry_t             ent_q, ent_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [OFF_W-1:0]   off_q, off_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_q, out_d;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    idx_d       = idx_q;
    off_d       = off_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    q_pop_o     = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          ent_d   = q_entry_i;
          state_d = BK_INDEX;
        end
      end
      BK_INDEX: begin
        // glyph index = row * 190 + column
        idx_d   = IDX_W'(IDX_W'(ent_q.row) * IDX_W'(GBK_ROW_SPAN)) + IDX_W'(ent_q.col);
        state_d = BK_SCALE;
      end
      BK_SCALE: begin
        off_d   = OFF_W'(idx_q) * OFF_W'(ent_q.nbytes);
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d       = 1'b1;
          out_d.draw_kind   = ent_q.kind;
          out_d.pos_x       = ent_q.pos_x;
          out_d.pos_y       = ent_q.pos_y;
          out_d.char_code   = ent_q.char_code;
          out_d.glyph_addr  = (ent_q.kind == DK_GLYPH) ?
                              cfg_i.font_base + ADDR_W'(off_q) : '0;
          out_d.glyph_bytes = ent_q.nbytes;
          out_d.overlay     = ent_q.overlay;
          state_d           = BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    idx_q <= idx_d;
    off_q <= off_d;
    out_q <= out_d;
  end

endmodule

// ----- hdl/gbk_text_layout.sv -----
// Text layout for a mixed ASCII/GBK byte stream: config registers, front
// end, command queue and back end. Depends on gbk_pkg and the defines header.
//
// Input stream: s_axis_tuser is the op (0 start a string at the box origin,
// 1 string byte), s_axis_tdata[7:0] the byte. Output stream: one transfer per
// drawn character; m_axis_tuser is the draw kind, m_axis_tdata the cell
// position, code and glyph bitmap address. Config: write cfg_data_i to
// register cfg_idx_i when cfg_we_i is high; write only while idle.
// The front end takes one byte per cycle while the command queue
// (QueueDepth entries) has room; bytes that draw nothing never leave it.
// The back end takes each command through load, index multiply, size
// multiply and result load, and pops the next command only once that
// result is loaded.
// When the receiver stalls, the result register holds, the back end waits
// with the next result, and the front end keeps taking bytes until the
// queue fills. Reset clears the cursor and text state, empties the queue
// and loads the register defaults (box 320 x 240, 16-pixel font).
`include "gbk_text_layout_defines.svh"

module gbk_text_layout #(
  parameter int QueueDepth = gbk_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] byte_value
  input  logic                             s_axis_tuser,  // [0] op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] pos_x, [31:16] pos_y, [39:32] char_code, [63:40] glyph_addr,
  // [70:64] glyph_bytes, [71] overlay
  output logic [71:0]                      m_axis_tdata,
  output logic [1:0]                       m_axis_tuser,  // [1:0] draw_kind
  input  logic                             cfg_we_i,
  input  logic [gbk_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gbk_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import gbk_pkg::*;

  cfg_t       cfg_q;
  logic       q_push, q_pop, q_full, q_empty;
  entry_t     q_in, q_out;
  fr_status_t fr_status;
  result_t    res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x     <= '0;
      cfg_q.origin_y     <= '0;
      cfg_q.box_width    <= BOX_WIDTH_RST;
      cfg_q.box_height   <= BOX_HEIGHT_RST;
      cfg_q.glyph_size   <= GLYPH_SIZE_RST;
      cfg_q.overlay_mode <= 1'b0;
      cfg_q.font_base    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:   cfg_q.origin_x     <= cfg_data_i[COORD_W-1:0];
        CFG_ORIGIN_Y:   cfg_q.origin_y     <= cfg_data_i[COORD_W-1:0];
        CFG_BOX_WIDTH:  cfg_q.box_width    <= cfg_data_i[COORD_W-1:0];
        CFG_BOX_HEIGHT: cfg_q.box_height   <= cfg_data_i[COORD_W-1:0];
        CFG_GLYPH_SIZE: cfg_q.glyph_size   <= cfg_data_i[SIZE_W-1:0];
        CFG_OVERLAY:    cfg_q.overlay_mode <= cfg_data_i[0];
        CFG_FONT_BASE:  cfg_q.font_base    <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  gbk_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_in),
    .status_o   (fr_status)
  );

  gbk_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  gbk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tuser = res.draw_kind;
  assign m_axis_tdata = {res.overlay, res.glyph_bytes, res.glyph_addr,
                         res.char_code, res.pos_y, res.pos_x};

  `GBK_ASSERT_IMP(a_push_has_room, q_push, !q_full, "command pushed into a full queue")
  `GBK_ASSERT_NEXT(a_start_clears, s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_START, !fr_status.halted && !fr_status.lead_pending && !fr_status.skip_after_cr, "start did not clear text state")
  `GBK_ASSERT_IMP(a_ascii_no_glyph, m_axis_tvalid && m_axis_tuser == DK_ASCII, m_axis_tdata[70:40] == '0, "ASCII result carries glyph fields")

endmodule

// ----- test/tb_gbk_text_layout.sv -----
// Self-checking testbench for gbk_text_layout: random ASCII/GBK strings go in
// through the byte stream, and each draw transfer is checked against a layout model.
// Depends on gbk_pkg and the RTL; reads no files.
module tb_gbk_text_layout;
  import gbk_pkg::*;

  localparam int ITEM_GOAL      = 1650;
  localparam int PHASE_ITEMS    = 150;
  localparam int SETTLE_CYCLES  = 16;
  localparam int SQUEEZE_CYCLES = 500;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic       op;
    logic [7:0] value;
  } stim_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata  = '0;
  logic                  s_axis_tuser  = OP_START;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [71:0]           m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Register copies
  logic [15:0] org_x = '0;
  logic [15:0] org_y = '0;
  logic [15:0] box_w = BOX_WIDTH_RST;
  logic [15:0] box_h = BOX_HEIGHT_RST;
  logic [4:0]  gsz   = GLYPH_SIZE_RST;
  logic        ovl   = 1'b0;
  logic [23:0] fbase = '0;

  // Text state
  logic [15:0] cur_x     = '0;
  logic [15:0] cur_y     = '0;
  logic [7:0]  lead_q    = '0;
  logic        lead_pend = 1'b0;
  logic        cr_skip   = 1'b0;
  logic        stopped   = 1'b0;

  stim_t   text_bytes[$];
  result_t pending_draws[$];

  int  items_pushed  = 0;
  int  items_taken   = 0;
  int  layout_items  = 0;
  int  err_cnt       = 0;
  int  n_ascii       = 0;
  int  n_glyph       = 0;
  int  n_blank       = 0;
  int  setting_count = 0;
  int  quiet_cycles  = 0;
  int  send_gap      = 0;
  int  stall_left    = 0;
  int  squeeze_left  = 0;
  bit  took          = 1'b0;
  bit  idle_on       = 1'b1;
  bit  squeeze_req   = 1'b0;

  gbk_text_layout dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------- layout model
  function automatic void next_line();
    cur_x = org_x;
    cur_y = cur_y + 16'(gsz);
  endfunction

  function automatic void wrap_line(int adv);
    if (int'(cur_x) > int'(org_x) + int'(box_w) - adv) next_line();
  endfunction

  function automatic bit below_box();
    return int'(cur_y) > int'(org_y) + int'(box_h) - int'(gsz);
  endfunction

  // Returns 1 when the byte draws a character; the draw command goes to r.
  function automatic bit layout_step(input logic op, input logic [7:0] b, output result_t r);
    int csize;
    int col;
    int off;
    r = '0;
    if (op == OP_START) begin
      layout_items++;
      cur_x     = org_x;
      cur_y     = org_y;
      lead_q    = '0;
      lead_pend = 1'b0;
      cr_skip   = 1'b0;
      stopped   = 1'b0;
      return 1'b0;
    end
    if (stopped) return 1'b0;
    layout_items++;
    if (b == CHAR_NUL) begin
      stopped   = 1'b1;
      lead_pend = 1'b0;
      cr_skip   = 1'b0;
      return 1'b0;
    end
    if (cr_skip) begin
      cr_skip = 1'b0;
      return 1'b0;
    end
    if (lead_pend) begin
      lead_pend = 1'b0;
      wrap_line(int'(gsz));
      if (below_box()) begin
        stopped = 1'b1;
        return 1'b0;
      end
      // Unsupported font heights move the cursor but draw nothing
      if (!(gsz == 5'd12 || gsz == 5'd16 || gsz == 5'd24)) begin
        cur_x = cur_x + 16'(gsz);
        return 1'b0;
      end
      csize         = ((int'(gsz) + 7) / 8) * int'(gsz);
      r.pos_x       = cur_x;
      r.pos_y       = cur_y;
      r.overlay     = ovl;
      r.glyph_bytes = 7'(csize);
      if (lead_q == CODE_INVALID || b < TRAIL_MIN || b == TRAIL_GAP || b == CODE_INVALID) begin
        r.draw_kind = DK_BLANK;
      end else begin
        col          = (b < TRAIL_GAP) ? int'(b) - int'(TRAIL_MIN) : int'(b) - int'(TRAIL_UP_BASE);
        off          = (GBK_ROW_SPAN * (int'(lead_q) - int'(LEAD_MIN)) + col) * csize;
        r.draw_kind  = DK_GLYPH;
        r.glyph_addr = 24'(off + int'(fbase));
      end
      cur_x = cur_x + 16'(gsz);
      return 1'b1;
    end
    if (b > ASCII_MAX) begin
      lead_q    = b;
      lead_pend = 1'b1;
      return 1'b0;
    end
    wrap_line(int'(gsz) / 2);
    if (below_box()) begin
      stopped = 1'b1;
      return 1'b0;
    end
    if (b == CHAR_CR) begin
      next_line();
      cr_skip = 1'b1;
      return 1'b0;
    end
    r.draw_kind = DK_ASCII;
    r.pos_x     = cur_x;
    r.pos_y     = cur_y;
    r.char_code = b;
    r.overlay   = ovl;
    cur_x = cur_x + 16'(gsz / 5'd2);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- helpers
  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void offer(logic op, logic [7:0] value);
    text_bytes.push_back('{op: op, value: value});
    items_pushed++;
  endfunction

  function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_ORIGIN_X:   org_x = val[15:0];
      CFG_ORIGIN_Y:   org_y = val[15:0];
      CFG_BOX_WIDTH:  box_w = val[15:0];
      CFG_BOX_HEIGHT: box_h = val[15:0];
      CFG_GLYPH_SIZE: gsz   = val[4:0];
      CFG_OVERLAY:    ovl   = val[0];
      CFG_FONT_BASE:  fbase = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every byte is taken and every draw has come out, then let
  // bytes that draw nothing clear the front end.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (items_taken != items_pushed || pending_draws.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic setup_phase(input int phase);
    logic [15:0] ox, oy, w, h;
    logic [4:0]  gs;
    logic        ov;
    logic [23:0] fb;
    ov = 1'($urandom_range(0, 1));
    fb = 24'($urandom);
    case (phase)
      1: begin ox = 0; oy = 0; w = 96; h = 48; gs = 12; ov = 1; fb = 24'hFFFFFF; end
      2: begin ox = 10; oy = 5; w = 200; h = 64; gs = 16; ov = 0; fb = 24'h000100; end
      3: begin ox = 16'hFFFF; oy = 16'hFFFF; w = 16'hFFFF; h = 16'hFFFF; gs = 24; end
      4: begin ox = 0; oy = 0; w = 0; h = 0; gs = 16; fb = 0; end
      5: begin
        ox = 16'($urandom_range(0, 500));
        oy = 16'($urandom_range(0, 500));
        w  = 120;
        h  = 100;
        do gs = 5'($urandom_range(0, 31));
        while (gs == 5'd12 || gs == 5'd16 || gs == 5'd24);
      end
      6: begin ox = 16'hFFF0; oy = 16'hFFE0; w = 64; h = 64; gs = 12; end
      default: begin
        ox = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        oy = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2000));
        w  = 16'($urandom_range(24, 400));
        h  = 16'($urandom_range(24, 300));
        case ($urandom_range(0, 9))
          0: gs = 5'($urandom_range(0, 31));
          1, 2, 3: gs = 12;
          4, 5, 6: gs = 16;
          default: gs = 24;
        endcase
      end
    endcase
    write_reg(CFG_ORIGIN_X, 24'(ox));
    write_reg(CFG_ORIGIN_Y, 24'(oy));
    write_reg(CFG_BOX_WIDTH, 24'(w));
    write_reg(CFG_BOX_HEIGHT, 24'(h));
    write_reg(CFG_GLYPH_SIZE, 24'(gs));
    write_reg(CFG_OVERLAY, 24'(ov));
    write_reg(CFG_FONT_BASE, fb);
    setting_count++;
  endtask

  // Mostly well-formed strings with random content, some noise.
  task automatic gen_phase(input int n_items);
    int         target;
    int         sel;
    logic [7:0] trail;
    target = items_pushed + n_items;
    while (items_pushed < target) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8))
          offer(($urandom_range(0, 7) != 0) ? OP_BYTE : OP_START, 8'($urandom));
      end else begin
        if ($urandom_range(0, 9) != 0) offer(OP_START, 8'($urandom));
        repeat ($urandom_range(1, 40)) begin
          sel = $urandom_range(0, 99);
          if (sel < 50) begin
            offer(OP_BYTE, 8'($urandom_range(8'h20, 8'h7E)));
          end else if (sel < 78) begin
            if ($urandom_range(0, 6) != 0) begin
              trail = 8'($urandom_range(8'h40, 8'hFE));
              if (trail == TRAIL_GAP) trail = 8'h80;
            end else begin
              trail = 8'($urandom);
            end
            offer(OP_BYTE, ($urandom_range(0, 9) != 0) ? 8'($urandom_range(8'h81, 8'hFE))
                                                       : CODE_INVALID);
            offer(OP_BYTE, trail);
          end else if (sel < 86) begin
            offer(OP_BYTE, CHAR_CR);
            offer(OP_BYTE, ($urandom_range(0, 3) != 0) ? 8'h0A : 8'($urandom));
          end else if (sel < 96) begin
            offer(OP_BYTE, 8'($urandom_range(1, 8'h80)));
          end else begin
            offer(OP_BYTE, 8'($urandom));
          end
        end
        if ($urandom_range(0, 9) < 7) offer(OP_BYTE, CHAR_NUL);
      end
    end
  endtask

  // ---------------------------------------------------------------- byte driver
  always @(posedge clk_i) begin : take_input
    result_t draw;
    if (s_axis_tvalid && s_axis_tready) begin
      if (layout_step(s_axis_tuser, s_axis_tdata, draw)) pending_draws.push_back(draw);
      items_taken++;
      took = 1'b1;
    end
  end

  always @(negedge clk_i) begin : drive_input
    stim_t item;
    if (!s_axis_tvalid || took) begin
      took = 1'b0;
      if (send_gap != 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (text_bytes.size() != 0) begin
        item = text_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item.value;
        s_axis_tuser  <= item.op;
        send_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- draw monitor
  always @(negedge clk_i) begin : drive_ready
    if (squeeze_req) begin
      squeeze_req  = 1'b0;
      squeeze_left = SQUEEZE_CYCLES;
    end
    if (squeeze_left != 0) begin
      squeeze_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin : check_draw
    result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      case (draw_kind_e'(m_axis_tuser))
        DK_ASCII: n_ascii++;
        DK_GLYPH: n_glyph++;
        DK_BLANK: n_blank++;
        default: ;
      endcase
      if (pending_draws.size() == 0) begin
        $error("draw transfer with none expected: kind %0d at (%0d,%0d)",
               m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16]);
        err_cnt++;
      end else begin
        want = pending_draws.pop_front();
        check_field("draw_kind", 24'(want.draw_kind), 24'(m_axis_tuser));
        check_field("pos_x", 24'(want.pos_x), 24'(m_axis_tdata[15:0]));
        check_field("pos_y", 24'(want.pos_y), 24'(m_axis_tdata[31:16]));
        check_field("char_code", 24'(want.char_code), 24'(m_axis_tdata[39:32]));
        check_field("glyph_addr", want.glyph_addr, m_axis_tdata[63:40]);
        check_field("glyph_bytes", 24'(want.glyph_bytes), 24'(m_axis_tdata[70:64]));
        check_field("overlay", 24'(want.overlay), 24'(m_axis_tdata[71]));
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int phase;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed strings at the reset settings
    offer(OP_START, 8'hA5);
    offer(OP_BYTE, 8'h41);
    offer(OP_BYTE, 8'h7E);
    offer(OP_BYTE, ASCII_MAX);                           // 0x80 stays ASCII
    offer(OP_BYTE, 8'h81); offer(OP_BYTE, 8'h40);        // first glyph of the table
    offer(OP_BYTE, 8'hFE); offer(OP_BYTE, 8'hFE);        // last glyph of the table
    offer(OP_BYTE, CODE_INVALID); offer(OP_BYTE, 8'h41); // bad lead
    offer(OP_BYTE, 8'h81); offer(OP_BYTE, 8'h3F);        // trail too low
    offer(OP_BYTE, 8'h82); offer(OP_BYTE, TRAIL_GAP);    // trail in the gap
    offer(OP_BYTE, 8'h83); offer(OP_BYTE, CODE_INVALID); // trail 0xFF
    offer(OP_BYTE, 8'h84); offer(OP_BYTE, 8'h80);        // first trail above the gap
    offer(OP_BYTE, 8'h85); offer(OP_BYTE, CHAR_CR);      // CR taken as trail
    offer(OP_BYTE, CHAR_CR); offer(OP_BYTE, 8'h0A);      // CR drops the LF
    offer(OP_BYTE, CHAR_CR); offer(OP_BYTE, CHAR_NUL);   // zero still ends after CR
    offer(OP_BYTE, 8'h41);                               // ignored once ended
    offer(OP_START, 8'h00);
    offer(OP_BYTE, 8'hC0);
    offer(OP_START, 8'hFF);                              // start drops the lead byte
    offer(OP_BYTE, 8'h90); offer(OP_BYTE, CHAR_NUL);     // zero discards the lead
    wait_drained();

    phase = 0;
    while (items_pushed < ITEM_GOAL) begin
      phase++;
      idle_on = (phase % 3 != 0);
      setup_phase(phase);
      if (phase == 2) squeeze_req = 1'b1;
      gen_phase(PHASE_ITEMS);
      wait_drained();
    end

    $display("Covered %0d text bytes (%0d not ignored) over %0d box/font settings,",
             items_taken, layout_items, setting_count);
    $display("with %0d ASCII, %0d glyph and %0d blank draws checked.", n_ascii, n_glyph,
             n_blank);
    if (err_cnt == 0 && pending_draws.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
